// ===== rtl/core/tft_pkg.sv =====
package tft_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned IN_W       = 32;
  localparam int unsigned ROT_W      = 16;
  localparam int unsigned ROT_FRAC   = 14;
  localparam int unsigned ROW_W      = AXES * ROT_W;
  localparam int unsigned TRANS_W    = 32;
  localparam int unsigned PROD_W     = ROT_W + IN_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned RND_W      = SUM_W - ROT_FRAC;
  localparam int unsigned CR_W       = TRANS_W + IN_W;
  localparam int unsigned CR_FRAC    = 16;
  localparam int unsigned CRD_W      = CR_W + 2;
  localparam int unsigned CRR_W      = CRD_W - CR_FRAC;
  localparam int unsigned LIN_W      = CRR_W + 1;
  localparam int unsigned IN_TDATA_W = 2 * AXES * IN_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = ROW_W;

  localparam logic signed [SUM_W-1:0] ROT_HALF = SUM_W'(1) <<< (ROT_FRAC - 1);
  localparam logic signed [CRD_W-1:0] CR_HALF  = CRD_W'(1) <<< (CR_FRAC - 1);

  localparam logic signed [63:0] SAT32_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT32_LO = ~SAT32_HI;

  localparam logic [ROW_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_ROW0 = 3'd0,
    CFG_ROT_ROW1 = 3'd1,
    CFG_ROT_ROW2 = 3'd2,
    CFG_TRANS_X  = 3'd3,
    CFG_TRANS_Y  = 3'd4,
    CFG_TRANS_Z  = 3'd5
  } tft_cfg_idx_e;

  typedef logic [AXES-1:0][ROW_W-1:0] tft_rot_t;
  typedef logic [AXES-1:0][IN_W-1:0]  tft_vec_t;
  typedef logic [AXES-1:0][RND_W-1:0] tft_rnd_t;

  // Stage enables of the matrix-vector unit
  typedef struct packed {
    logic prod;
    logic sum;
  } tft_mac_en_t;

  function automatic logic signed [63:0] sat64(input logic signed [63:0] x,
                                               input logic signed [63:0] hi,
                                               input logic signed [63:0] lo);
    logic signed [63:0] r;
    r = x;
    if (x > hi) r = hi;
    else if (x < lo) r = lo;
    return r;
  endfunction

endpackage

// ===== rtl/core/tft_rot_mac.sv =====
// Rotation times vector in two stages: nine products, then row sums
// rounded from Q20.30 to Q20.16.
module tft_rot_mac
  import tft_pkg::*;
(
  input  logic        clk_i,
  input  tft_mac_en_t en_i,
  input  tft_rot_t    rot_i,
  input  tft_vec_t    vec_i,
  output tft_rnd_t    res_o
);

  logic signed [PROD_W-1:0] prod_d [AXES][AXES];
  logic signed [PROD_W-1:0] prod_q [AXES][AXES];
  tft_rnd_t                 res_d, res_q;

  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      for (int c = 0; c < AXES; c++) begin
        prod_d[r][c] = PROD_W'($signed(rot_i[r][c*ROT_W +: ROT_W])) *
                       PROD_W'($signed(vec_i[c]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) prod_q <= prod_d;
  end

  // Add half an LSB, then floor shift
  always_comb begin
    logic signed [SUM_W-1:0] sum_v;
    for (int r = 0; r < AXES; r++) begin
      sum_v = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2]) + ROT_HALF;
      res_d[r] = sum_v[SUM_W-1:ROT_FRAC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/twist_frame_transform_unit.sv =====
// Channel  | Direction | Handshake             | Content
// s_axis   | in        | tvalid/tready         | source twist word
// m_axis   | out       | tvalid/tready         | target twist word
// cfg      | in        | cfg_valid/cfg_ready   | register index and value
//
// Six register stages: products, row sums, saturate, cross products,
// cross difference, final add. One word per cycle while m_axis is not stalled.
// Each stage holds a valid bit; a stage loads when it is empty or the next
// one advances, so bubbles close up and a stall at m_axis holds every word.
// Reset clears the valid bits and loads the identity rotation, zero offset.
// cfg_ready_o stays high; writes go straight to the registers.
module twist_frame_transform_unit
  import tft_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // ang_in_x, ang_in_y, ang_in_z, lin_in_x, lin_in_y, lin_in_z (32 b each)
  input  logic [IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // ang_out_x, ang_out_y, ang_out_z, lin_out_x, lin_out_y, lin_out_z
  // (DATA_WIDTH b each), zero padded to whole bytes
  output logic [((6*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned DW         = DATA_WIDTH;
  localparam int unsigned OUT_TDATA_W = ((6*DATA_WIDTH+7)/8)*8;
  localparam logic signed [63:0] DW_HI = 64'sh7FFF_FFFF_FFFF_FFFF >>> (64 - DATA_WIDTH);
  localparam logic signed [63:0] DW_LO = ~DW_HI;
  localparam int unsigned STAGES = 6;

  // Configuration registers
  tft_rot_t                   rot_q;
  logic signed [TRANS_W-1:0]  trans_q [AXES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= ROT_ROW0_RST;
      rot_q[1]   <= ROT_ROW1_RST;
      rot_q[2]   <= ROT_ROW2_RST;
      trans_q[0] <= '0;
      trans_q[1] <= '0;
      trans_q[2] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROT_ROW0: rot_q[0]   <= cfg_data_i;
        CFG_ROT_ROW1: rot_q[1]   <= cfg_data_i;
        CFG_ROT_ROW2: rot_q[2]   <= cfg_data_i;
        CFG_TRANS_X:  trans_q[0] <= cfg_data_i[TRANS_W-1:0];
        CFG_TRANS_Y:  trans_q[1] <= cfg_data_i[TRANS_W-1:0];
        CFG_TRANS_Z:  trans_q[2] <= cfg_data_i[TRANS_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Pipeline control: valid bit per stage, enable chain from the output
  logic [STAGES:1] v_q;
  logic [STAGES:1] en;

  always_comb begin
    en[STAGES] = !v_q[STAGES] || m_axis_tready_i;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= s_axis_tvalid_i;
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready_o = en[1];
  assign m_axis_tvalid_o = v_q[STAGES];

  // Stages 1 and 2: R*w and R*v
  tft_vec_t    ang_in, lin_in;
  tft_rnd_t    w_rnd, v_rnd;
  tft_mac_en_t mac_en;

  assign ang_in = s_axis_tdata_i[AXES*IN_W-1:0];
  assign lin_in = s_axis_tdata_i[2*AXES*IN_W-1:AXES*IN_W];
  assign mac_en = '{prod: en[1], sum: en[2]};

  tft_rot_mac u_ang_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .rot_i (rot_q),
    .vec_i (ang_in),
    .res_o (w_rnd)
  );

  tft_rot_mac u_lin_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .rot_i (rot_q),
    .vec_i (lin_in),
    .res_o (v_rnd)
  );

  // Stage 3: saturate w_b to output width, and to 32 bits for the cross term
  logic [AXES-1:0][DW-1:0]   wb_d, wb3_q, wb4_q, wb5_q;
  logic signed [IN_W-1:0]    wc_d [AXES];
  logic signed [IN_W-1:0]    wc_q [AXES];
  logic signed [RND_W-1:0]   vr3_q [AXES];
  logic signed [RND_W-1:0]   vr4_q [AXES];
  logic signed [RND_W-1:0]   vr5_q [AXES];

  always_comb begin
    logic signed [63:0] w64, wsat, csat;
    for (int r = 0; r < AXES; r++) begin
      w64  = 64'($signed(w_rnd[r]));
      wsat = sat64(w64, DW_HI, DW_LO);
      csat = sat64(wsat, SAT32_HI, SAT32_LO);
      wb_d[r] = wsat[DW-1:0];
      wc_d[r] = csat[IN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      wb3_q <= wb_d;
      wc_q  <= wc_d;
      for (int r = 0; r < AXES; r++) vr3_q[r] <= $signed(v_rnd[r]);
    end
  end

  // Stage 4: the six products of t x w_b
  logic signed [CR_W-1:0] cp_d [2*AXES];
  logic signed [CR_W-1:0] cp_q [2*AXES];

  always_comb begin
    cp_d[0] = CR_W'(trans_q[1]) * CR_W'(wc_q[2]);
    cp_d[1] = CR_W'(trans_q[2]) * CR_W'(wc_q[1]);
    cp_d[2] = CR_W'(trans_q[2]) * CR_W'(wc_q[0]);
    cp_d[3] = CR_W'(trans_q[0]) * CR_W'(wc_q[2]);
    cp_d[4] = CR_W'(trans_q[0]) * CR_W'(wc_q[1]);
    cp_d[5] = CR_W'(trans_q[1]) * CR_W'(wc_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      cp_q  <= cp_d;
      wb4_q <= wb3_q;
      vr4_q <= vr3_q;
    end
  end

  // Stage 5: cross difference, rounded from Q34.32 to Q34.16
  logic signed [CRR_W-1:0] cr_d [AXES];
  logic signed [CRR_W-1:0] cr_q [AXES];

  always_comb begin
    logic signed [CRD_W-1:0] diff;
    for (int r = 0; r < AXES; r++) begin
      diff = CRD_W'(cp_q[2*r]) - CRD_W'(cp_q[2*r+1]) + CR_HALF;
      cr_d[r] = diff[CRD_W-1:CR_FRAC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      cr_q  <= cr_d;
      wb5_q <= wb4_q;
      vr5_q <= vr4_q;
    end
  end

  // Stage 6: add the two linear terms and saturate; this is the output word
  logic [AXES-1:0][DW-1:0] lin_d, ang_q, lin_q;

  always_comb begin
    logic signed [LIN_W-1:0] sum_v;
    logic signed [63:0]      lsat;
    for (int r = 0; r < AXES; r++) begin
      sum_v = LIN_W'(cr_q[r]) + LIN_W'(vr5_q[r]);
      lsat  = sat64(64'(sum_v), DW_HI, DW_LO);
      lin_d[r] = lsat[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      ang_q <= wb5_q;
      lin_q <= lin_d;
    end
  end

  assign m_axis_tdata_o = OUT_TDATA_W'({lin_q, ang_q});

`ifndef SYNTHESIS
  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  a_ready_follows_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output drains");

  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == '1 && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("word taken into a full stalled pipeline");

  a_word_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (int'($countones(v_q)) == int'($past($countones(v_q)))
                       + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("word lost or repeated in pipeline");
`endif

endmodule
